@@ rtl/rma_pkg.sv @@
// Shared types and constants for the rotation matrix accumulator.
// Item kind codes, sequencer states, CORDIC arctangent steps and gain.
// No dependencies.
`default_nettype none

package rma_pkg;

  // Width of the vector fields and the transformed result
  localparam int VEC_WIDTH = 32;

  // CORDIC gain as a 32-bit fraction
  localparam logic [63:0] GAIN_Q32 = 64'd2608131496;

  typedef enum logic [2:0] {
    KIND_IDENT = 3'd0,
    KIND_ROT_X = 3'd1,
    KIND_ROT_Y = 3'd2,
    KIND_ROT_Z = 3'd3,
    KIND_XFORM = 3'd4
  } rma_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MAC,
    ST_DRAIN,
    ST_DELIVER
  } rma_state_e;

  // Arctangent of 2^-i in binary angle units; zero from step 31 on
  function automatic logic [31:0] atan_step(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0:    r = 32'd536870912;
      6'd1:    r = 32'd316933406;
      6'd2:    r = 32'd167458907;
      6'd3:    r = 32'd85004756;
      6'd4:    r = 32'd42667331;
      6'd5:    r = 32'd21354465;
      6'd6:    r = 32'd10679838;
      6'd7:    r = 32'd5340245;
      6'd8:    r = 32'd2670163;
      6'd9:    r = 32'd1335087;
      6'd10:   r = 32'd667544;
      6'd11:   r = 32'd333772;
      6'd12:   r = 32'd166886;
      6'd13:   r = 32'd83443;
      6'd14:   r = 32'd41722;
      6'd15:   r = 32'd20861;
      6'd16:   r = 32'd10430;
      6'd17:   r = 32'd5215;
      6'd18:   r = 32'd2608;
      6'd19:   r = 32'd1304;
      6'd20:   r = 32'd652;
      6'd21:   r = 32'd326;
      6'd22:   r = 32'd163;
      6'd23:   r = 32'd81;
      6'd24:   r = 32'd41;
      6'd25:   r = 32'd20;
      6'd26:   r = 32'd10;
      6'd27:   r = 32'd5;
      6'd28:   r = 32'd3;
      6'd29:   r = 32'd1;
      6'd30:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Gain rounded half up to frac fraction bits (elaboration only)
  function automatic logic [63:0] cordic_gain(input int frac);
    logic [63:0] r;
    if (frac >= 32) begin
      r = GAIN_Q32 << (frac - 32);
    end else begin
      r = (GAIN_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rma_cordic.sv @@
// Iterative CORDIC sine/cosine unit, one micro-rotation per cycle.
// Depends on rma_pkg (arctangent steps, gain).
`default_nettype none

module rma_cordic #(
  parameter int WORD_WIDTH   = 32,
  parameter int CORDIC_STEPS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [31:0]           angle_i,
  output logic                         done_o,
  output logic signed [WORD_WIDTH-1:0] cos_o,
  output logic signed [WORD_WIDTH-1:0] sin_o,
  output logic signed [WORD_WIDTH-1:0] nsin_o
);

  localparam int Frac = WORD_WIDTH - 2;
  localparam int XW   = WORD_WIDTH + 1;
  localparam int ZW   = 34;
  localparam int CW   = $clog2(CORDIC_STEPS);
  localparam logic [63:0]          Gain     = rma_pkg::cordic_gain(Frac);
  localparam logic [CW-1:0]        LastStep = CW'(CORDIC_STEPS - 1);
  localparam logic signed [ZW-1:0] Quarter  = 34'sd1073741824;
  localparam logic signed [ZW-1:0] Half     = 34'sd2147483648;

  logic                 busy_q, fin_q, done_q;
  logic [CW-1:0]        cnt_q;
  logic signed [XW-1:0] x_q, y_q, x_d, y_d, dx, dy;
  logic signed [ZW-1:0] z_q, z_d, z0, ang, st;
  logic                 flip_q, flip0;
  logic signed [XW-1:0] c_full, s_full, ns_full;
  logic signed [WORD_WIDTH-1:0] cos_q, sin_q, nsin_q;

  // fold into [-pi/2, pi/2]
  always_comb begin
    ang   = ZW'(angle_i);
    z0    = ang;
    flip0 = 1'b0;
    if (ang > Quarter) begin
      z0    = ang - Half;
      flip0 = 1'b1;
    end else if (ang < -Quarter) begin
      z0    = ang + Half;
      flip0 = 1'b1;
    end
  end

  always_comb begin
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    st = $signed(ZW'(rma_pkg::atan_step(6'(cnt_q))));
    if (!z_q[ZW-1]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - st;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + st;
    end
    c_full  = flip_q ? -x_q : x_q;
    s_full  = flip_q ? -y_q : y_q;
    ns_full = flip_q ? y_q : -y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= XW'(Gain);
      y_q    <= '0;
      z_q    <= z0;
      flip_q <= flip0;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (fin_q) begin
      cos_q  <= c_full[WORD_WIDTH-1:0];
      sin_q  <= s_full[WORD_WIDTH-1:0];
      nsin_q <= ns_full[WORD_WIDTH-1:0];
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign nsin_o = nsin_q;

endmodule

`default_nettype wire

@@ rtl/rotation_matrix_accumulator_unit.sv @@
// Kind 0 (identity reload) and kinds 5 to 7: the block stays idle and is ready again next cycle.
// Kinds 1 to 3: busy through the CORDIC loop, then 27 products through the one shared
//   multiplier, then drain and commit.
// Kind 4: result registered after 9 products, drain and hand-off.
// Throughput is one item at a time, set by the shared multiplier and the CORDIC loop.
// Reset (async, active low) loads the identity matrix and empties all control state.
`default_nettype none

module rotation_matrix_accumulator_unit #(
  parameter int WORD_WIDTH   = 32,
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] angle_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               saturated_o
);

  localparam int W    = WORD_WIDTH;
  localparam int Frac = W - 2;
  localparam int VW   = rma_pkg::VEC_WIDTH;
  // second multiplier operand covers both rotation entries and vector words
  localparam int BW   = (W > VW) ? W : VW;
  localparam int PW   = W + BW;
  // three-term sum needs two guard bits
  localparam int AW   = PW + 2;
  localparam int SW   = AW - Frac;

  localparam logic signed [W-1:0] One     = {2'b01, {Frac{1'b0}}};
  localparam logic [AW-1:0]       RndHalf = {{(AW - Frac){1'b0}}, 1'b1, {(Frac - 1){1'b0}}};

  // which value a rotation matrix entry takes
  typedef enum logic [2:0] {
    RS_ZERO,
    RS_ONE,
    RS_COS,
    RS_SIN,
    RS_NSIN
  } rma_rsel_e;

  // Elementary rotations, row-major position k*3+j
  //   X: [1 0 0; 0 c s; 0 -s c]
  //   Y: [c 0 -s; 0 1 0; s 0 c]
  //   Z: [c s 0; -s c 0; 0 0 1]
  function automatic rma_rsel_e rot_entry(input logic [2:0] kind, input logic [3:0] idx);
    rma_rsel_e r;
    r = RS_ZERO;
    case (kind)
      rma_pkg::KIND_ROT_X: begin
        case (idx)
          4'd0:    r = RS_ONE;
          4'd4:    r = RS_COS;
          4'd5:    r = RS_SIN;
          4'd7:    r = RS_NSIN;
          4'd8:    r = RS_COS;
          default: r = RS_ZERO;
        endcase
      end
      rma_pkg::KIND_ROT_Y: begin
        case (idx)
          4'd0:    r = RS_COS;
          4'd2:    r = RS_NSIN;
          4'd4:    r = RS_ONE;
          4'd6:    r = RS_SIN;
          4'd8:    r = RS_COS;
          default: r = RS_ZERO;
        endcase
      end
      rma_pkg::KIND_ROT_Z: begin
        case (idx)
          4'd0:    r = RS_COS;
          4'd1:    r = RS_SIN;
          4'd3:    r = RS_NSIN;
          4'd4:    r = RS_COS;
          4'd8:    r = RS_ONE;
          default: r = RS_ZERO;
        endcase
      end
      default: r = RS_ZERO;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  rma_pkg::rma_state_e state_q, state_d;
  logic [1:0]          i_q, i_d, j_q, j_d, k_q, k_d;
  logic [2:0]          kind_q;
  logic                vec_mode_q;
  logic signed [31:0]  vec_q [3];

  // stored matrix and the product being built
  logic signed [W-1:0] m_q [9];
  logic signed [W-1:0] t_q [9];

  // stage 1: product
  logic signed [PW-1:0] prod_q;
  logic                 p_v_q, p_first_q, p_last_q;
  logic [3:0]           p_idx_q;
  // stage 2: accumulation
  logic signed [AW-1:0] acc_q;
  logic                 a_v_q;
  logic [3:0]           a_idx_q;

  logic signed [31:0]   res_q [3];
  logic                 sat_q;
  logic signed [31:0]   out_x_q, out_y_q, out_z_q;
  logic                 out_valid_q, out_sat_q;

  // ---------------------------------------------------------------------------
  // CORDIC
  // ---------------------------------------------------------------------------
  logic                accept, is_rot, cordic_start, cordic_done;
  logic signed [W-1:0] cos_w, sin_w, nsin_w;

  assign accept       = in_valid_i && (state_q == rma_pkg::ST_IDLE);
  assign is_rot       = (kind_i == rma_pkg::KIND_ROT_X) || (kind_i == rma_pkg::KIND_ROT_Y) ||
                        (kind_i == rma_pkg::KIND_ROT_Z);
  assign cordic_start = accept && is_rot;

  rma_cordic #(
    .WORD_WIDTH  (WORD_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cordic_start),
    .angle_i(angle_i),
    .done_o (cordic_done),
    .cos_o  (cos_w),
    .sin_o  (sin_w),
    .nsin_o (nsin_w)
  );

  // ---------------------------------------------------------------------------
  // Operand selection for the shared multiplier
  // ---------------------------------------------------------------------------
  logic [3:0]          m_idx, r_idx, e_idx;
  logic signed [W-1:0] op_a, op_r;
  logic signed [BW-1:0] op_b;
  logic [1:0]          jmax;
  logic                last_issue;

  always_comb begin
    m_idx = ({2'b00, i_q} * 4'd3) + {2'b00, k_q};
    r_idx = ({2'b00, k_q} * 4'd3) + {2'b00, j_q};
    e_idx = vec_mode_q ? {2'b00, i_q} : (({2'b00, i_q} * 4'd3) + {2'b00, j_q});
    op_a  = m_q[m_idx];
    case (rot_entry(kind_q, r_idx))
      RS_ONE:  op_r = One;
      RS_COS:  op_r = cos_w;
      RS_SIN:  op_r = sin_w;
      RS_NSIN: op_r = nsin_w;
      default: op_r = '0;
    endcase
    op_b       = vec_mode_q ? BW'(vec_q[k_q]) : BW'(op_r);
    jmax       = vec_mode_q ? 2'd0 : 2'd2;
    last_issue = (k_q == 2'd2) && (j_q == jmax) && (i_q == 2'd2);
  end

  // ---------------------------------------------------------------------------
  // Round half up, shift by Frac, clip
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] rnd, shf;
  logic signed [SW-1:0] sh;
  logic [SW-W:0]        top_w;
  logic [SW-VW:0]       top_v;
  logic                 fits_w, fits_v;
  logic signed [W-1:0]  fin_w;
  logic signed [31:0]   fin_v;

  always_comb begin
    rnd    = acc_q + $signed(RndHalf);
    shf    = rnd >>> Frac;
    sh     = shf[SW-1:0];
    top_w  = sh[SW-1:W-1];
    top_v  = sh[SW-1:VW-1];
    fits_w = (&top_w) || !(|top_w);
    fits_v = (&top_v) || !(|top_v);
    fin_w  = fits_w ? sh[W-1:0] : {sh[SW-1], {(W - 1){~sh[SW-1]}}};
    fin_v  = fits_v ? sh[VW-1:0] : {sh[SW-1], {(VW - 1){~sh[SW-1]}}};
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic commit, out_load, load_ident;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    commit     = 1'b0;
    out_load   = 1'b0;
    load_ident = 1'b0;
    case (state_q)
      rma_pkg::ST_IDLE: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
        if (accept) begin
          if (kind_i == rma_pkg::KIND_IDENT) begin
            load_ident = 1'b1;
          end else if (kind_i == rma_pkg::KIND_XFORM) begin
            state_d = rma_pkg::ST_MAC;
          end else if (is_rot) begin
            state_d = rma_pkg::ST_ROT;
          end
        end
      end
      rma_pkg::ST_ROT: begin
        if (cordic_done) begin
          state_d = rma_pkg::ST_MAC;
        end
      end
      rma_pkg::ST_MAC: begin
        if (k_q == 2'd2) begin
          k_d = '0;
          if (j_q == jmax) begin
            j_d = '0;
            if (last_issue) begin
              i_d     = '0;
              state_d = rma_pkg::ST_DRAIN;
            end else begin
              i_d = i_q + 2'd1;
            end
          end else begin
            j_d = j_q + 2'd1;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      rma_pkg::ST_DRAIN: begin
        if (!p_v_q && !a_v_q) begin
          if (vec_mode_q) begin
            state_d = rma_pkg::ST_DELIVER;
          end else begin
            commit  = 1'b1;
            state_d = rma_pkg::ST_IDLE;
          end
        end
      end
      rma_pkg::ST_DELIVER: begin
        // wait for the output register to be free
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = rma_pkg::ST_IDLE;
        end
      end
      default: state_d = rma_pkg::ST_IDLE;
    endcase
  end

  // control and matrix state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rma_pkg::ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      p_v_q       <= 1'b0;
      a_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int n = 0; n < 9; n++) begin
        m_q[n] <= (n == 0 || n == 4 || n == 8) ? One : '0;
      end
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      p_v_q       <= (state_q == rma_pkg::ST_MAC);
      a_v_q       <= p_v_q && p_last_q;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (load_ident) begin
        for (int n = 0; n < 9; n++) begin
          m_q[n] <= (n == 0 || n == 4 || n == 8) ? One : '0;
        end
      end else if (commit) begin
        for (int n = 0; n < 9; n++) begin
          m_q[n] <= t_q[n];
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_i;
      vec_mode_q <= (kind_i == rma_pkg::KIND_XFORM);
      vec_q[0]   <= vec_x_i;
      vec_q[1]   <= vec_y_i;
      vec_q[2]   <= vec_z_i;
      sat_q      <= 1'b0;
    end else if (a_v_q && vec_mode_q) begin
      sat_q <= sat_q || !fits_v;
    end

    // stage 1
    prod_q    <= op_a * op_b;
    p_first_q <= (k_q == 2'd0);
    p_last_q  <= (k_q == 2'd2);
    p_idx_q   <= e_idx;

    // stage 2: exact three-term sum
    if (p_v_q) begin
      acc_q   <= p_first_q ? AW'(prod_q) : acc_q + AW'(prod_q);
      a_idx_q <= p_idx_q;
    end

    // stage 3: round and clip into place
    if (a_v_q) begin
      if (vec_mode_q) begin
        res_q[a_idx_q[1:0]] <= fin_v;
      end else begin
        t_q[a_idx_q] <= fin_w;
      end
    end

    if (out_load) begin
      out_x_q   <= res_q[0];
      out_y_q   <= res_q[1];
      out_z_q   <= res_q[2];
      out_sat_q <= sat_q;
    end
  end

  assign in_stall_o  = (state_q != rma_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign saturated_o = out_sat_q;

endmodule

`default_nettype wire

@@ rtl/rma_checker.sv @@
// Port-level assertions for the rotation matrix accumulator, bound to the top level.
// Depends on rma_pkg (kind codes) and rotation_matrix_accumulator_unit.
`default_nettype none

module rma_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [2:0]  kind_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] out_x_o,
  input wire logic [31:0] out_y_o,
  input wire logic [31:0] out_z_o,
  input wire logic        saturated_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_x_o) && $stable(out_y_o) &&
      $stable(out_z_o) && $stable(saturated_o))
    else $error("result word changed while stalled");

  // rotations and transforms occupy the block
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (kind_i == rma_pkg::KIND_ROT_X || kind_i == rma_pkg::KIND_ROT_Y ||
      kind_i == rma_pkg::KIND_ROT_Z || kind_i == rma_pkg::KIND_XFORM) |=> in_stall_o)
    else $error("block ready straight after a multi-cycle word");

  // identity reload and unused kinds finish at once
  a_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (kind_i == rma_pkg::KIND_IDENT || kind_i > rma_pkg::KIND_XFORM) |=> !in_stall_o)
    else $error("single-cycle word left the block busy");

  // a result appears only out of a transform in progress
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word with no transform in progress");

endmodule

bind rotation_matrix_accumulator_unit rma_checker u_rma_checker (.*);

`default_nettype wire
